// File: hdl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and character constants for the command-line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int CHAR_W  = 21;
    localparam int START_W = 16;
    localparam int END_W   = 17;
    localparam int INDEX_W = 16;

    localparam logic [CHAR_W-1:0] CH_BLANK  = 21'h00020;
    localparam logic [CHAR_W-1:0] CH_TAB    = 21'h00009;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 21'h00022;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 21'h00027;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 21'h0005C;

    typedef enum logic [5:0] {
        ST_NONE   = 6'b000001,
        ST_DQ     = 6'b000010,
        ST_SQ     = 6'b000100,
        ST_DQ_ESC = 6'b001000,
        ST_SQ_ESC = 6'b010000,
        ST_BARE   = 6'b100000
    } scan_state_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } char_item_t;

    typedef struct packed {
        logic               token_valid;
        logic [START_W-1:0] token_start;
        logic [END_W-1:0]   token_end;
        logic [INDEX_W-1:0] token_index;
        logic               list_end;
        logic               overflow;
    } tok_item_t;

endpackage

// File: hdl/command_line_tokenizer_top.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer_top
// Splits a command string, one character per item, into argument tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Characters enter on the char channel (valid/ready), one code point per
//   item, with is_last set on the final character of a string. Tokens leave
//   on the tok channel (valid/ready) as start, end (exclusive) and index.
//   A character that closes a token yields one item; the last character
//   always yields one item marked list_end, carrying any non-empty token still
//   open. Other characters yield nothing.
// Timing:
//   One character per cycle sustained while the tok channel takes results. An
//   item passes an input register and then a result register, so a token is
//   registered in the result register after the character that closes it.
//   The per-character scan decision lies between the two registers.
// Stall:
//   While a result waits on the tok channel, characters that give no result
//   keep flowing; a character that gives one waits in the input register.
// Reset:
//   rst_n clears the scan state, position, token count and overflow flag.
//   The same state is restored after each last character.
// ----------------------------------------------------------------------------
module command_line_tokenizer_top #(
    parameter int MAX_LEN = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_ready,
    input  clt_pkg::char_item_t char_item,
    output logic                tok_valid,
    input  logic                tok_ready,
    output clt_pkg::tok_item_t  tok_item
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int EW = (PW > clt_pkg::END_W) ? PW : clt_pkg::END_W;
    localparam logic [PW-1:0] MAX_POS   = PW'(MAX_LEN);
    localparam logic [EW-1:0] START_SAT = EW'((1 << clt_pkg::START_W) - 1);
    localparam logic [EW-1:0] END_SAT   = EW'((1 << clt_pkg::END_W) - 1);
    localparam logic [clt_pkg::INDEX_W-1:0] COUNT_SAT = '1;

    logic                 s1_valid_reg;
    clt_pkg::char_item_t  s1_item_reg;

    clt_pkg::scan_state_t scan_state_reg, scan_state_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [PW-1:0]        open_start_reg, open_start_next;
    logic [clt_pkg::INDEX_W-1:0] count_reg, count_next;
    logic                 ovf_reg, ovf_next;

    logic                 tok_valid_reg;
    clt_pkg::tok_item_t   tok_item_reg;

    logic                 s1_go;
    logic                 out_free;
    logic                 emit;
    logic                 found;
    logic                 at_max;
    logic                 ovf_eff;
    logic [PW-1:0]        nxt;
    logic [PW-1:0]        fs, fe;
    logic [EW-1:0]        fs_ext, fe_ext;
    logic                 is_sep, is_dq, is_sq, is_bs;
    logic [clt_pkg::CHAR_W-1:0] ch;
    logic                 last;
    clt_pkg::tok_item_t   result;

    assign ch     = s1_item_reg.char_code;
    assign last   = s1_item_reg.is_last;
    assign is_sep = (ch == clt_pkg::CH_BLANK) || (ch == clt_pkg::CH_TAB);
    assign is_dq  = (ch == clt_pkg::CH_DQUOTE);
    assign is_sq  = (ch == clt_pkg::CH_SQUOTE);
    assign is_bs  = (ch == clt_pkg::CH_BSLASH);

    // Position never exceeds MAX_LEN, so reaching it means this character overflows.
    assign at_max  = (pos_reg == MAX_POS);
    assign ovf_eff = ovf_reg | at_max;
    assign nxt     = at_max ? pos_reg : pos_reg + PW'(1);

    always_comb
    begin
        scan_state_next = scan_state_reg;
        open_start_next = open_start_reg;
        found           = 1'b0;
        fs              = open_start_reg;
        fe              = pos_reg;
        unique case (scan_state_reg)
            clt_pkg::ST_NONE:
            begin
                if (is_sep)
                begin
                    scan_state_next = clt_pkg::ST_NONE;
                end
                else if (is_dq)
                begin
                    scan_state_next = clt_pkg::ST_DQ;
                    open_start_next = nxt;
                end
                else if (is_sq)
                begin
                    scan_state_next = clt_pkg::ST_SQ;
                    open_start_next = nxt;
                end
                else
                begin
                    scan_state_next = clt_pkg::ST_BARE;
                    open_start_next = pos_reg;
                end
            end
            clt_pkg::ST_BARE:
            begin
                if (is_sep)
                begin
                    found           = 1'b1;
                    scan_state_next = clt_pkg::ST_NONE;
                end
                else if (is_dq || is_sq)
                begin
                    found           = 1'b1;
                    open_start_next = nxt;
                    scan_state_next = is_dq ? clt_pkg::ST_DQ : clt_pkg::ST_SQ;
                end
            end
            clt_pkg::ST_DQ:
            begin
                if (is_bs)
                begin
                    scan_state_next = clt_pkg::ST_DQ_ESC;
                end
                else if (is_dq)
                begin
                    found           = 1'b1;
                    scan_state_next = clt_pkg::ST_NONE;
                end
            end
            clt_pkg::ST_SQ:
            begin
                if (is_bs)
                begin
                    scan_state_next = clt_pkg::ST_SQ_ESC;
                end
                else if (is_sq)
                begin
                    found           = 1'b1;
                    scan_state_next = clt_pkg::ST_NONE;
                end
            end
            clt_pkg::ST_DQ_ESC: scan_state_next = clt_pkg::ST_DQ;
            clt_pkg::ST_SQ_ESC: scan_state_next = clt_pkg::ST_SQ;
            default:            scan_state_next = clt_pkg::ST_NONE;
        endcase

        // On the last character a still-open, non-empty token is flushed.
        if (!found && last && (scan_state_next != clt_pkg::ST_NONE)
            && (open_start_next < nxt))
        begin
            found = 1'b1;
            fs    = open_start_next;
            fe    = nxt;
        end
    end

    assign emit   = found || last;
    assign fs_ext = EW'(fs);
    assign fe_ext = EW'(fe);

    always_comb
    begin
        result.token_valid = found;
        result.token_start = '0;
        result.token_end   = '0;
        result.token_index = '0;
        if (found)
        begin
            result.token_start = (fs_ext > START_SAT) ? START_SAT[clt_pkg::START_W-1:0]
                                                      : fs_ext[clt_pkg::START_W-1:0];
            result.token_end   = (fe_ext > END_SAT) ? END_SAT[clt_pkg::END_W-1:0]
                                                    : fe_ext[clt_pkg::END_W-1:0];
            result.token_index = count_reg;
        end
        result.list_end = last;
        result.overflow = ovf_eff;
    end

    assign out_free   = !tok_valid_reg || tok_ready;
    assign s1_go      = s1_valid_reg && (!emit || out_free);
    assign char_ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        pos_next   = nxt;
        ovf_next   = ovf_eff;
        count_next = count_reg;
        if (found && (count_reg != COUNT_SAT))
        begin
            count_next = count_reg + clt_pkg::INDEX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (char_ready)
        begin
            s1_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            s1_item_reg <= char_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_state_reg <= clt_pkg::ST_NONE;
            pos_reg        <= '0;
            open_start_reg <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (s1_go)
        begin
            if (last)
            begin
                scan_state_reg <= clt_pkg::ST_NONE;
                pos_reg        <= '0;
                open_start_reg <= '0;
                count_reg      <= '0;
                ovf_reg        <= 1'b0;
            end
            else
            begin
                scan_state_reg <= scan_state_next;
                pos_reg        <= pos_next;
                open_start_reg <= open_start_next;
                count_reg      <= count_next;
                ovf_reg        <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else if (s1_go && emit)
        begin
            tok_valid_reg <= 1'b1;
        end
        else if (tok_ready)
        begin
            tok_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && emit)
        begin
            tok_item_reg <= result;
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok_item  = tok_item_reg;

endmodule

// File: hdl/clt_checker.sv
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks on the token channel of the command-line tokenizer.
// ----------------------------------------------------------------------------
module clt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               tok_valid,
    input logic               tok_ready,
    input clt_pkg::tok_item_t tok_item
);

    // A stalled result must hold until it is taken.
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok_item))
        else $error("token item changed while stalled");

    // A result without a token carries zero position and index fields.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_item.token_valid |->
            (tok_item.token_start == '0) && (tok_item.token_end == '0)
            && (tok_item.token_index == '0))
        else $error("empty result has nonzero fields");

    // A token never ends before it starts.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.token_valid |->
            ({1'b0, tok_item.token_start} <= tok_item.token_end))
        else $error("token end precedes token start");

    // Only the list-end result may come without a token.
    a_mid_token: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_item.list_end |-> tok_item.token_valid)
        else $error("result without token before end of list");

endmodule

bind command_line_tokenizer_top clt_checker u_clt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_item  (tok_item)
);

// File: bench/clt_token_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clt_token_checker
// Watches both channels of the command-line tokenizer, predicts the token
// items from every accepted character and compares them in order.
// ----------------------------------------------------------------------------
module clt_token_checker #(
    parameter int MAX_LEN = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    input  logic                char_ready,
    input  clt_pkg::char_item_t char_item,
    input  logic                tok_valid,
    input  logic                tok_ready,
    input  clt_pkg::tok_item_t  tok_item,
    output int                  errors,
    output int                  pending,
    output int                  tokens_checked
);

    localparam logic [clt_pkg::END_W-1:0] LEN_CAP = clt_pkg::END_W'(MAX_LEN);

    clt_pkg::scan_state_t        scan_st;
    logic [clt_pkg::END_W-1:0]   char_pos;
    logic [clt_pkg::END_W-1:0]   tok_open_start;
    logic [clt_pkg::INDEX_W-1:0] tok_count;
    logic                        len_overflow;
    clt_pkg::tok_item_t          expected_tokens[$];
    clt_pkg::tok_item_t          want;

    task automatic clear_scan();
        begin
            scan_st        = clt_pkg::ST_NONE;
            char_pos       = '0;
            tok_open_start = '0;
            tok_count      = '0;
            len_overflow   = 1'b0;
        end
    endtask

    // Advances the scan by one character and queues the token item it causes.
    task automatic scan_char(input clt_pkg::char_item_t c);
        logic [clt_pkg::END_W-1:0] p;
        logic [clt_pkg::END_W-1:0] nxt;
        logic [clt_pkg::END_W-1:0] fs;
        logic [clt_pkg::END_W-1:0] fe;
        logic                      found;
        logic                      is_sep;
        clt_pkg::tok_item_t        r;
        begin
            found  = 1'b0;
            fs     = '0;
            fe     = '0;
            is_sep = (c.char_code == clt_pkg::CH_BLANK) || (c.char_code == clt_pkg::CH_TAB);
            if (char_pos >= LEN_CAP)
            begin
                len_overflow = 1'b1;
                char_pos     = LEN_CAP;
            end
            p   = char_pos;
            nxt = (p < LEN_CAP) ? p + clt_pkg::END_W'(1) : LEN_CAP;

            case (scan_st)
                clt_pkg::ST_NONE:
                begin
                    if (is_sep)
                    begin
                    end
                    else if (c.char_code == clt_pkg::CH_DQUOTE)
                    begin
                        scan_st        = clt_pkg::ST_DQ;
                        tok_open_start = nxt;
                    end
                    else if (c.char_code == clt_pkg::CH_SQUOTE)
                    begin
                        scan_st        = clt_pkg::ST_SQ;
                        tok_open_start = nxt;
                    end
                    else
                    begin
                        scan_st        = clt_pkg::ST_BARE;
                        tok_open_start = p;
                    end
                end
                clt_pkg::ST_BARE:
                begin
                    if (is_sep)
                    begin
                        found   = 1'b1;
                        fs      = tok_open_start;
                        fe      = p;
                        scan_st = clt_pkg::ST_NONE;
                    end
                    else if (c.char_code == clt_pkg::CH_DQUOTE
                             || c.char_code == clt_pkg::CH_SQUOTE)
                    begin
                        // A quote closes the bare token and opens a quoted one.
                        found          = 1'b1;
                        fs             = tok_open_start;
                        fe             = p;
                        tok_open_start = nxt;
                        scan_st        = (c.char_code == clt_pkg::CH_DQUOTE) ?
                                         clt_pkg::ST_DQ : clt_pkg::ST_SQ;
                    end
                end
                clt_pkg::ST_DQ:
                begin
                    if (c.char_code == clt_pkg::CH_BSLASH)
                        scan_st = clt_pkg::ST_DQ_ESC;
                    else if (c.char_code == clt_pkg::CH_DQUOTE)
                    begin
                        found   = 1'b1;
                        fs      = tok_open_start;
                        fe      = p;
                        scan_st = clt_pkg::ST_NONE;
                    end
                end
                clt_pkg::ST_SQ:
                begin
                    if (c.char_code == clt_pkg::CH_BSLASH)
                        scan_st = clt_pkg::ST_SQ_ESC;
                    else if (c.char_code == clt_pkg::CH_SQUOTE)
                    begin
                        found   = 1'b1;
                        fs      = tok_open_start;
                        fe      = p;
                        scan_st = clt_pkg::ST_NONE;
                    end
                end
                clt_pkg::ST_DQ_ESC: scan_st = clt_pkg::ST_DQ;
                clt_pkg::ST_SQ_ESC: scan_st = clt_pkg::ST_SQ;
                default:            scan_st = clt_pkg::ST_NONE;
            endcase

            char_pos = nxt;

            // The last character flushes a token that is open and not empty.
            if (!found && c.is_last && scan_st != clt_pkg::ST_NONE
                && tok_open_start < char_pos)
            begin
                found = 1'b1;
                fs    = tok_open_start;
                fe    = char_pos;
            end

            if (found || c.is_last)
            begin
                r.token_valid = found;
                r.token_start = !found ? '0 :
                                (fs > 17'h0FFFF) ? 16'hFFFF : fs[clt_pkg::START_W-1:0];
                r.token_end   = found ? fe : '0;
                r.token_index = found ? tok_count : '0;
                r.list_end    = c.is_last;
                r.overflow    = len_overflow;
                expected_tokens.push_back(r);
                if (found && tok_count != 16'hFFFF)
                    tok_count = tok_count + clt_pkg::INDEX_W'(1);
                if (c.is_last)
                    clear_scan();
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        begin
            if (want_v != got_v)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            expected_tokens.delete();
            errors         = 0;
            tokens_checked = 0;
        end
        else
        begin
            if (char_valid && char_ready)
                scan_char(char_item);
            if (tok_valid && tok_ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("token item with none expected: start %0d end %0d index %0d",
                           tok_item.token_start, tok_item.token_end, tok_item.token_index);
                    errors++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("token_valid", 32'(want.token_valid),
                                32'(tok_item.token_valid));
                    check_field("token_start", 32'(want.token_start),
                                32'(tok_item.token_start));
                    check_field("token_end", 32'(want.token_end),
                                32'(tok_item.token_end));
                    check_field("token_index", 32'(want.token_index),
                                32'(tok_item.token_index));
                    check_field("list_end", 32'(want.list_end),
                                32'(tok_item.list_end));
                    check_field("overflow", 32'(want.overflow),
                                32'(tok_item.overflow));
                    tokens_checked++;
                end
            end
        end
        pending = expected_tokens.size();
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives command strings into the tokenizer one character per item: a
// directed set of quoting cases and random strings, with random stalls on
// both channels and one long hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_LEN      = 65536;
    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_CHARS = 1520;
    localparam int HOLD_CYCLES  = 400;

    logic                clk;
    logic                rst_n;
    logic                char_valid;
    logic                char_ready;
    clt_pkg::char_item_t char_item;
    logic                tok_valid;
    logic                tok_ready;
    clt_pkg::tok_item_t  tok_item;

    int errors;
    int pending;
    int tokens_checked;
    int tx_idle_pct  = 29;
    int rx_idle_pct  = 29;
    int rx_hold      = 0;
    int chars_sent   = 0;
    int strings_sent = 0;
    int quiet_cycles = 0;

    logic [clt_pkg::CHAR_W-1:0] str_buf[$];

    command_line_tokenizer_top #(
        .MAX_LEN(MAX_LEN)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_valid(char_valid),
        .char_ready(char_ready),
        .char_item (char_item),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item)
    );

    clt_token_checker #(
        .MAX_LEN(MAX_LEN)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_ready    (char_ready),
        .char_item     (char_item),
        .tok_valid     (tok_valid),
        .tok_ready     (tok_ready),
        .tok_item      (tok_item),
        .errors        (errors),
        .pending       (pending),
        .tokens_checked(tokens_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls, plus a hold-off counted down here when requested.
    initial
    begin
        tok_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                tok_ready <= 1'b0;
                rx_hold   = rx_hold - 1;
            end
            else
                tok_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && char_ready) || (tok_valid && tok_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("command_line_tokenizer_top verification failed");
                $finish;
            end
        end
    end

    task automatic send_char(input logic [clt_pkg::CHAR_W-1:0] code, input logic last);
        begin
            @(negedge clk);
            while ($urandom_range(99) < tx_idle_pct)
            begin
                char_valid <= 1'b0;
                @(negedge clk);
            end
            char_valid <= 1'b1;
            char_item  <= '{char_code: code, is_last: last};
            @(posedge clk);
            while (!char_ready)
                @(posedge clk);
            chars_sent++;
        end
    endtask

    // Sends the buffered string, with is_last on its final character.
    task automatic send_buffer();
        begin
            for (int i = 0; i < str_buf.size(); i++)
                send_char(str_buf[i], i == str_buf.size() - 1);
            str_buf.delete();
            strings_sent++;
        end
    endtask

    task automatic queue_text(input string s);
        begin
            for (int i = 0; i < s.len(); i++)
                str_buf.push_back(clt_pkg::CHAR_W'(s[i]));
        end
    endtask

    // Mostly separators, quotes, escapes and letters, now and then any code point.
    function automatic logic [clt_pkg::CHAR_W-1:0] random_code();
        int unsigned pick;
        begin
            pick = $urandom_range(99);
            if (pick < 16)
                return clt_pkg::CH_BLANK;
            else if (pick < 21)
                return clt_pkg::CH_TAB;
            else if (pick < 31)
                return clt_pkg::CH_DQUOTE;
            else if (pick < 39)
                return clt_pkg::CH_SQUOTE;
            else if (pick < 46)
                return clt_pkg::CH_BSLASH;
            else if (pick < 86)
                return clt_pkg::CHAR_W'($urandom_range(8'h7a, 8'h61));
            else
                return clt_pkg::CHAR_W'($urandom());
        end
    endfunction

    initial
    begin
        int  len;
        int  rand_chars;
        bit  hold_done;
        bit  noise;

        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_item  = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Bare token flushed at the end, then a string of only a blank.
        queue_text("x");
        send_buffer();
        queue_text(" ");
        send_buffer();
        // Quote after blanks, closed by the last character.
        queue_text("\t\"a b\"");
        send_buffer();
        // Quote inside a bare token, and an escaped quote inside single quotes.
        queue_text("a'b\\'c'");
        send_buffer();
        // Empty quotes.
        queue_text("\"\"");
        send_buffer();
        // Extreme code points are ordinary characters.
        str_buf.push_back(21'h1FFFFF);
        str_buf.push_back(21'h000000);
        str_buf.push_back(clt_pkg::CH_BLANK);
        str_buf.push_back(21'h10FFFF);
        send_buffer();
        // Unterminated quote, and a string ending on an escape.
        queue_text("\"ab");
        send_buffer();
        queue_text("'\\");
        send_buffer();

        rand_chars = 0;
        hold_done  = 1'b0;
        while (rand_chars < RANDOM_CHARS)
        begin
            if (!hold_done && rand_chars >= 500)
            begin
                rx_hold   = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (rand_chars >= 1000 && rand_chars < 1250)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = 29;
                rx_idle_pct = 29;
            end
            len   = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
            noise = ($urandom_range(9) == 0);
            for (int i = 0; i < len; i++)
                str_buf.push_back(noise ? clt_pkg::CHAR_W'($urandom()) : random_code());
            rand_chars += len;
            send_buffer();
        end

        @(negedge clk);
        char_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Summary: %0d characters in %0d strings, %0d token items checked.",
                 chars_sent, strings_sent, tokens_checked);
        $display("Covered quoting, escapes, empty and open quotes, odd code points and stalls.");
        if (errors == 0)
            $display("command_line_tokenizer_top verification clean");
        else
            $display("command_line_tokenizer_top verification failed");
        $finish;
    end

endmodule
